[design/mwm_pkg.sv]
// ----------------------------------------------------------------------------
// Maze wall map package
// Grid size, field widths, move codes and the structs that pass between the
// map store and the step decision logic.
// ----------------------------------------------------------------------------
package mwm_pkg;

   localparam int MAZE_SIDE = 16;
   localparam int CELLS     = MAZE_SIDE * MAZE_SIDE;
   localparam int COL_W     = $clog2(MAZE_SIDE);
   localparam int ROW_W     = $clog2(MAZE_SIDE);
   localparam int CNT_W     = $clog2(CELLS + 1);

   localparam int POS_W    = 4;
   localparam int HEAD_W   = 2;
   localparam int DIST_W   = 12;
   localparam int THRESH_W = 12;
   localparam int MOVE_W   = 3;

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(100);

   // absolute sides, same coding as the heading field
   localparam logic [HEAD_W-1:0] SIDE_UP    = 2'd0;
   localparam logic [HEAD_W-1:0] SIDE_RIGHT = 2'd1;
   localparam logic [HEAD_W-1:0] SIDE_DOWN  = 2'd2;
   localparam logic [HEAD_W-1:0] SIDE_LEFT  = 2'd3;

   typedef enum logic [MOVE_W-1:0] {
      MV_FORWARD = 3'd0,
      MV_RIGHT   = 3'd1,
      MV_BACK    = 3'd2,
      MV_LEFT    = 3'd3,
      MV_AROUND  = 3'd4,
      MV_NONE    = 3'd5,
      MV_STUCK   = 3'd6
   } move_type;

   typedef logic [MAZE_SIDE-1:0]   vis_row_type;
   typedef logic [4*MAZE_SIDE-1:0] wall_row_type;

   // three visited rows around the current cell and the wall row of the cell
   typedef struct packed {
      vis_row_type  vis_up;
      vis_row_type  vis_cur;
      vis_row_type  vis_dn;
      wall_row_type wall_cur;
   } map_rows_type;

   // one row write per map for a finished step
   typedef struct packed {
      logic             vis_we;
      logic [ROW_W-1:0] vis_row;
      vis_row_type      vis_data;
      logic             wall_we;
      logic [ROW_W-1:0] wall_row;
      wall_row_type     wall_data;
   } map_wr_type;

   // turn needed to face a side, given side minus heading
   function automatic move_type turn_move(input logic [HEAD_W-1:0] rel);
      move_type m;
      unique case (rel)
         2'd0:    m = MV_FORWARD;
         2'd1:    m = MV_RIGHT;
         2'd2:    m = MV_AROUND;
         default: m = MV_LEFT;
      endcase
      return m;
   endfunction

endpackage

[design/mwm_ifs.sv]
// ----------------------------------------------------------------------------
// Maze wall map channels
// Valid/ready channels for the step request and the step response.
// ----------------------------------------------------------------------------
interface mwm_req_if;
   logic                             valid;
   logic                             ready;
   logic [mwm_pkg::POS_W-1:0]        pos_x;
   logic [mwm_pkg::POS_W-1:0]        pos_y;
   logic [mwm_pkg::HEAD_W-1:0]       heading;
   logic [mwm_pkg::DIST_W-1:0]       dist_front;
   logic [mwm_pkg::DIST_W-1:0]       dist_left;
   logic [mwm_pkg::DIST_W-1:0]       dist_right;

   modport source (output valid, pos_x, pos_y, heading, dist_front, dist_left, dist_right,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, heading, dist_front, dist_left, dist_right,
                   output ready);
endinterface

interface mwm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mwm_pkg::MOVE_W-1:0]  move_code;
   logic                        all_explored;
   logic                        dead_end;

   modport source (output valid, move_code, all_explored, dead_end, input ready);
   modport sink   (input valid, move_code, all_explored, dead_end, output ready);
endinterface

[design/mwm_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module mwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/mwm_map.sv]
// ----------------------------------------------------------------------------
// Maze wall map store
// Row-organized visited and wall memories, row valid bits for reset, and a
// bypass of the last write so a step sees the one just before it.
// ----------------------------------------------------------------------------
module mwm_map (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [mwm_pkg::POS_W-1:0] rd_y,
   input  mwm_pkg::map_wr_type       wr,
   output mwm_pkg::map_rows_type     rows
);

   logic [mwm_pkg::ROW_W-1:0] rd_cur, rd_up, rd_dn;
   logic [mwm_pkg::ROW_W-1:0] up_row_ff, cur_row_ff, dn_row_ff;

   logic [mwm_pkg::MAZE_SIDE-1:0] vis_vld_ff, vis_vld_in;
   logic [mwm_pkg::MAZE_SIDE-1:0] wall_vld_ff, wall_vld_in;

   logic                      vfwd_vld_ff;
   logic [mwm_pkg::ROW_W-1:0] vfwd_row_ff;
   mwm_pkg::vis_row_type      vfwd_data_ff;
   logic                      wfwd_vld_ff;
   logic [mwm_pkg::ROW_W-1:0] wfwd_row_ff;
   mwm_pkg::wall_row_type     wfwd_data_ff;

   mwm_pkg::vis_row_type  up_q, cur_q, dn_q;
   mwm_pkg::wall_row_type wall_q;

   // reset contents of a visited row: only the start cell is set
   function automatic mwm_pkg::vis_row_type vis_reset_word(
      input logic [mwm_pkg::ROW_W-1:0] r);
      mwm_pkg::vis_row_type w;
      w    = '0;
      w[0] = (r == '0);
      return w;
   endfunction

   assign rd_cur = mwm_pkg::ROW_W'(rd_y);
   assign rd_up  = rd_cur + mwm_pkg::ROW_W'(1);
   assign rd_dn  = rd_cur - mwm_pkg::ROW_W'(1);

   mwm_ram #(.WIDTH(mwm_pkg::MAZE_SIDE), .DEPTH(mwm_pkg::MAZE_SIDE)) u_vis_up (
      .clock   (clock),
      .wr_en   (wr.vis_we),
      .wr_addr (wr.vis_row),
      .wr_data (wr.vis_data),
      .rd_en   (rd_en),
      .rd_addr (rd_up),
      .rd_data (up_q)
   );

   mwm_ram #(.WIDTH(mwm_pkg::MAZE_SIDE), .DEPTH(mwm_pkg::MAZE_SIDE)) u_vis_cur (
      .clock   (clock),
      .wr_en   (wr.vis_we),
      .wr_addr (wr.vis_row),
      .wr_data (wr.vis_data),
      .rd_en   (rd_en),
      .rd_addr (rd_cur),
      .rd_data (cur_q)
   );

   mwm_ram #(.WIDTH(mwm_pkg::MAZE_SIDE), .DEPTH(mwm_pkg::MAZE_SIDE)) u_vis_dn (
      .clock   (clock),
      .wr_en   (wr.vis_we),
      .wr_addr (wr.vis_row),
      .wr_data (wr.vis_data),
      .rd_en   (rd_en),
      .rd_addr (rd_dn),
      .rd_data (dn_q)
   );

   mwm_ram #(.WIDTH(4*mwm_pkg::MAZE_SIDE), .DEPTH(mwm_pkg::MAZE_SIDE)) u_wall (
      .clock   (clock),
      .wr_en   (wr.wall_we),
      .wr_addr (wr.wall_row),
      .wr_data (wr.wall_data),
      .rd_en   (rd_en),
      .rd_addr (rd_cur),
      .rd_data (wall_q)
   );

   always_comb begin
      vis_vld_in  = vis_vld_ff;
      wall_vld_in = wall_vld_ff;
      if (wr.vis_we) begin
         vis_vld_in[wr.vis_row] = 1'b1;
      end
      if (wr.wall_we) begin
         wall_vld_in[wr.wall_row] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vis_vld_ff  <= '0;
         wall_vld_ff <= '0;
         vfwd_vld_ff <= 1'b0;
         wfwd_vld_ff <= 1'b0;
      end else begin
         vis_vld_ff  <= vis_vld_in;
         wall_vld_ff <= wall_vld_in;
         if (wr.vis_we) begin
            vfwd_vld_ff <= 1'b1;
         end
         if (wr.wall_we) begin
            wfwd_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         up_row_ff  <= rd_up;
         cur_row_ff <= rd_cur;
         dn_row_ff  <= rd_dn;
      end
      if (wr.vis_we) begin
         vfwd_row_ff  <= wr.vis_row;
         vfwd_data_ff <= wr.vis_data;
      end
      if (wr.wall_we) begin
         wfwd_row_ff  <= wr.wall_row;
         wfwd_data_ff <= wr.wall_data;
      end
   end

   // last write wins, then stored row, then reset contents
   always_comb begin
      if (vfwd_vld_ff && vfwd_row_ff == up_row_ff) begin
         rows.vis_up = vfwd_data_ff;
      end else if (vis_vld_ff[up_row_ff]) begin
         rows.vis_up = up_q;
      end else begin
         rows.vis_up = vis_reset_word(up_row_ff);
      end

      if (vfwd_vld_ff && vfwd_row_ff == cur_row_ff) begin
         rows.vis_cur = vfwd_data_ff;
      end else if (vis_vld_ff[cur_row_ff]) begin
         rows.vis_cur = cur_q;
      end else begin
         rows.vis_cur = vis_reset_word(cur_row_ff);
      end

      if (vfwd_vld_ff && vfwd_row_ff == dn_row_ff) begin
         rows.vis_dn = vfwd_data_ff;
      end else if (vis_vld_ff[dn_row_ff]) begin
         rows.vis_dn = dn_q;
      end else begin
         rows.vis_dn = vis_reset_word(dn_row_ff);
      end

      // grid edge sides are forced blocked downstream, so unwritten rows read open
      if (wfwd_vld_ff && wfwd_row_ff == cur_row_ff) begin
         rows.wall_cur = wfwd_data_ff;
      end else if (wall_vld_ff[cur_row_ff]) begin
         rows.wall_cur = wall_q;
      end else begin
         rows.wall_cur = '0;
      end
   end

endmodule

[design/mwm_decide.sv]
// ----------------------------------------------------------------------------
// Maze wall map step decision
// Records the three readings, picks the move and builds the map row writes
// and the new visited count for one step.
// ----------------------------------------------------------------------------
module mwm_decide (
   input  logic [mwm_pkg::POS_W-1:0]    pos_x,
   input  logic [mwm_pkg::POS_W-1:0]    pos_y,
   input  logic [mwm_pkg::HEAD_W-1:0]   heading,
   input  logic [mwm_pkg::DIST_W-1:0]   dist_front,
   input  logic [mwm_pkg::DIST_W-1:0]   dist_left,
   input  logic [mwm_pkg::DIST_W-1:0]   dist_right,
   input  logic [mwm_pkg::THRESH_W-1:0] wall_threshold,
   input  mwm_pkg::map_rows_type        rows,
   input  logic [mwm_pkg::CNT_W-1:0]    count,
   output mwm_pkg::move_type            move_code,
   output logic                         dead_end,
   output logic                         all_explored,
   output logic [mwm_pkg::CNT_W-1:0]    count_next,
   output mwm_pkg::map_wr_type          wr
);

   logic [mwm_pkg::COL_W-1:0]  col, col_p, col_m, tgt_col;
   logic [mwm_pkg::ROW_W-1:0]  row, tgt_row;
   logic                       in_grid, found, vis_set, vis_clr;
   logic [3:0]                 at_edge, cell_walls, new_wall, blocked, nvis, cand;
   logic [mwm_pkg::HEAD_W-1:0] side_l, side_r, side_b, pick, tgt;
   mwm_pkg::vis_row_type       tgt_word;

   assign col     = mwm_pkg::COL_W'(pos_x);
   assign col_p   = col + mwm_pkg::COL_W'(1);
   assign col_m   = col - mwm_pkg::COL_W'(1);
   assign row     = mwm_pkg::ROW_W'(pos_y);
   assign in_grid = (int'(pos_x) < mwm_pkg::MAZE_SIDE) && (int'(pos_y) < mwm_pkg::MAZE_SIDE);

   assign side_l = heading + 2'd3;
   assign side_r = heading + 2'd1;
   assign side_b = heading + 2'd2;

   always_comb begin
      at_edge[mwm_pkg::SIDE_UP]    = (int'(pos_y) == mwm_pkg::MAZE_SIDE - 1);
      at_edge[mwm_pkg::SIDE_RIGHT] = (int'(pos_x) == mwm_pkg::MAZE_SIDE - 1);
      at_edge[mwm_pkg::SIDE_DOWN]  = (pos_y == '0);
      at_edge[mwm_pkg::SIDE_LEFT]  = (pos_x == '0);

      // fresh readings replace the stored sides they cover; back side is kept
      cell_walls = rows.wall_cur[{col, 2'b00} +: 4];
      new_wall            = cell_walls;
      new_wall[heading]   = dist_front < wall_threshold;
      new_wall[side_l]    = dist_left  < wall_threshold;
      new_wall[side_r]    = dist_right < wall_threshold;
      blocked             = at_edge | new_wall;

      nvis[mwm_pkg::SIDE_UP]    = rows.vis_up[col];
      nvis[mwm_pkg::SIDE_RIGHT] = rows.vis_cur[col_p];
      nvis[mwm_pkg::SIDE_DOWN]  = rows.vis_dn[col];
      nvis[mwm_pkg::SIDE_LEFT]  = rows.vis_cur[col_m];
      cand = ~blocked & ~nvis;

      // try up, left, right, down
      found = 1'b1;
      if (cand[mwm_pkg::SIDE_UP]) begin
         pick = mwm_pkg::SIDE_UP;
      end else if (cand[mwm_pkg::SIDE_LEFT]) begin
         pick = mwm_pkg::SIDE_LEFT;
      end else if (cand[mwm_pkg::SIDE_RIGHT]) begin
         pick = mwm_pkg::SIDE_RIGHT;
      end else if (cand[mwm_pkg::SIDE_DOWN]) begin
         pick = mwm_pkg::SIDE_DOWN;
      end else begin
         found = 1'b0;
         pick  = mwm_pkg::SIDE_UP;
      end

      move_code = mwm_pkg::MV_NONE;
      dead_end  = 1'b0;
      vis_set   = 1'b0;
      vis_clr   = 1'b0;
      tgt       = pick;
      if (in_grid) begin
         if (found) begin
            move_code = mwm_pkg::turn_move(pick - heading);
            vis_set   = (pick == heading);
         end else if (count != mwm_pkg::CNT_W'(mwm_pkg::CELLS)) begin
            if (blocked[heading] && blocked[side_l] && blocked[side_r]) begin
               move_code = mwm_pkg::MV_AROUND;
               dead_end  = 1'b1;
               tgt       = side_b;
               vis_clr   = !at_edge[side_b] && nvis[side_b];
            end else begin
               move_code = mwm_pkg::MV_STUCK;
            end
         end
      end

      case (tgt)
         mwm_pkg::SIDE_UP: begin
            tgt_row  = row + mwm_pkg::ROW_W'(1);
            tgt_col  = col;
            tgt_word = rows.vis_up;
         end
         mwm_pkg::SIDE_RIGHT: begin
            tgt_row  = row;
            tgt_col  = col_p;
            tgt_word = rows.vis_cur;
         end
         mwm_pkg::SIDE_DOWN: begin
            tgt_row  = row - mwm_pkg::ROW_W'(1);
            tgt_col  = col;
            tgt_word = rows.vis_dn;
         end
         default: begin
            tgt_row  = row;
            tgt_col  = col_m;
            tgt_word = rows.vis_cur;
         end
      endcase

      wr.vis_we            = vis_set | vis_clr;
      wr.vis_row           = tgt_row;
      wr.vis_data          = tgt_word;
      wr.vis_data[tgt_col] = vis_set;

      wr.wall_we                        = in_grid;
      wr.wall_row                       = row;
      wr.wall_data                      = rows.wall_cur;
      wr.wall_data[{col, 2'b00} +: 4]   = new_wall;

      if (vis_set) begin
         count_next = count + mwm_pkg::CNT_W'(1);
      end else if (vis_clr) begin
         count_next = count - mwm_pkg::CNT_W'(1);
      end else begin
         count_next = count;
      end
      all_explored = (count_next == mwm_pkg::CNT_W'(mwm_pkg::CELLS));
   end

endmodule

[design/maze_wall_map_explore_step.sv]
// ----------------------------------------------------------------------------
// Maze wall map explore step
// Records walls around the current cell and picks the next exploration move.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one transfer per step: cell position, heading and the front, left
//          and right distance readings.
//   rsp  - one transfer per step, in order: move code, all-explored flag and
//          dead-end flag.
//   csr  - write the 12-bit wall threshold while no step is in flight.
// Path: a step transferred on req waits in the input stage, moves into the
//   response register once that register is free, and is offered on rsp.
// Throughput: one step per cycle while rsp takes each response. Consecutive
//   steps see each other's map updates through a bypass of the last row write
//   in the map store, so the decision logic between the input stage and the
//   response register never waits.
// Reset: threshold 100, every interior side open, only cell (0,0) visited,
//   visited count one. Row valid bits stand in for the reset contents, so no
//   clearing pass runs and req is ready straight out of reset.
// Stall: a response waits in its register; the input stage still takes one
//   more step, then req.ready drops until rsp.ready frees the response.
// ----------------------------------------------------------------------------
module maze_wall_map_explore_step (
   input  logic                         clock,
   input  logic                         reset,
   mwm_req_if.sink                      req,
   mwm_rsp_if.source                    rsp,
   input  logic                         csr_wr_en,
   input  logic [mwm_pkg::THRESH_W-1:0] csr_wr_data
);

   // handshake
   logic accept, fire, rsp_free;

   // input stage
   logic                         in_vld_ff, in_vld_in;
   logic [mwm_pkg::POS_W-1:0]    in_x_ff, in_y_ff;
   logic [mwm_pkg::HEAD_W-1:0]   in_head_ff;
   logic [mwm_pkg::DIST_W-1:0]   in_front_ff, in_left_ff, in_right_ff;

   // threshold register and visited count
   logic [mwm_pkg::THRESH_W-1:0] thr_ff;
   logic [mwm_pkg::CNT_W-1:0]    count_ff, count_in;

   // response register
   logic                         rsp_vld_ff, rsp_vld_in;
   mwm_pkg::move_type            rsp_move_ff;
   logic                         rsp_all_ff, rsp_dead_ff;

   // map and decision
   mwm_pkg::map_rows_type        map_rows;
   mwm_pkg::map_wr_type          dec_wr, map_wr;
   mwm_pkg::move_type            dec_move;
   logic                         dec_dead, dec_all;
   logic [mwm_pkg::CNT_W-1:0]    dec_count;

   // Advance the input stage whenever the response register can take a result.
   assign rsp_free  = !rsp_vld_ff || rsp.ready;
   assign fire      = in_vld_ff && rsp_free;
   assign req.ready = !in_vld_ff || fire;
   assign accept    = req.valid && req.ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end

      rsp_vld_in = rsp_vld_ff;
      if (fire) begin
         rsp_vld_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_vld_in = 1'b0;
      end

      count_in = fire ? dec_count : count_ff;

      // Drop the map writes of a step until it moves into the response register.
      map_wr         = dec_wr;
      map_wr.vis_we  = dec_wr.vis_we && fire;
      map_wr.wall_we = dec_wr.wall_we && fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         count_ff   <= mwm_pkg::CNT_W'(1);
         thr_ff     <= mwm_pkg::THRESH_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         count_ff   <= count_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   // Hold the step fields in the input stage; the map reads its rows in the same edge.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_x_ff     <= req.pos_x;
         in_y_ff     <= req.pos_y;
         in_head_ff  <= req.heading;
         in_front_ff <= req.dist_front;
         in_left_ff  <= req.dist_left;
         in_right_ff <= req.dist_right;
      end
      if (fire) begin
         rsp_move_ff <= dec_move;
         rsp_all_ff  <= dec_all;
         rsp_dead_ff <= dec_dead;
      end
   end

   mwm_map u_map (
      .clock (clock),
      .reset (reset),
      .rd_en (accept),
      .rd_y  (req.pos_y),
      .wr    (map_wr),
      .rows  (map_rows)
   );

   mwm_decide u_decide (
      .pos_x          (in_x_ff),
      .pos_y          (in_y_ff),
      .heading        (in_head_ff),
      .dist_front     (in_front_ff),
      .dist_left      (in_left_ff),
      .dist_right     (in_right_ff),
      .wall_threshold (thr_ff),
      .rows           (map_rows),
      .count          (count_ff),
      .move_code      (dec_move),
      .dead_end       (dec_dead),
      .all_explored   (dec_all),
      .count_next     (dec_count),
      .wr             (dec_wr)
   );

   assign rsp.valid        = rsp_vld_ff;
   assign rsp.move_code    = rsp_move_ff;
   assign rsp.all_explored = rsp_all_ff;
   assign rsp.dead_end     = rsp_dead_ff;

   // An empty input stage always takes a transfer.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |-> req.ready)
      else $error("input stage empty but req not ready");

   // A dead end always turns around.
   a_dead_turns: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_dead_ff |-> rsp_move_ff == mwm_pkg::MV_AROUND)
      else $error("dead end without turn around");

   // The pending response agrees with the visited count it left behind.
   a_explored_count: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> rsp_all_ff == (count_ff == mwm_pkg::CNT_W'(mwm_pkg::CELLS)))
      else $error("all_explored disagrees with visited count");

   // The visited count moves only when a step completes.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(count_ff))
      else $error("visited count changed without a step");

endmodule
